// ===== rtl/chb_pkg.sv =====
// Package for the chunked body decoder: phase and status codes, widths,
// the result word type and the hex digit decode. No dependencies.
`timescale 1ns / 1ps

package chb_pkg;

	localparam int MAX_DIGITS  = 31;
	localparam int SIZE_BITS   = 32;
	localparam int TOTAL_BITS  = 32;
	localparam int HEX_BITS    = $clog2(16);
	localparam int DIGIT_BITS  = $clog2(MAX_DIGITS + 1);

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	localparam logic [DIGIT_BITS-1:0] DIGITS_MAX = DIGIT_BITS'(MAX_DIGITS);

	// Parser phases, one-hot
	typedef enum logic [8:0] {
		PH_SIZE    = 9'b000000001,
		PH_SIZE_LF = 9'b000000010,
		PH_DATA    = 9'b000000100,
		PH_DATA_CR = 9'b000001000,
		PH_DATA_LF = 9'b000010000,
		PH_LAST_CR = 9'b000100000,
		PH_LAST_LF = 9'b001000000,
		PH_DONE    = 9'b010000000,
		PH_ERROR   = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// One result word
	typedef struct packed {
		logic [7:0]            payload_byte;
		logic                  payload_valid;
		status_t               decode_status;
		logic [TOTAL_BITS-1:0] decoded_total;
	} result_t;

	typedef struct packed {
		logic                ok;
		logic [HEX_BITS-1:0] val;
	} hex_t;

	// Decode one ASCII hex digit
	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t r;
		r.ok  = 1'b1;
		r.val = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.val = HEX_BITS'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.val = HEX_BITS'(b - 8'h61 + 8'd10);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.val = HEX_BITS'(b - 8'h41 + 8'd10);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/chb_parser.sv =====
// Parser state and next-state logic for the chunked body decoder.
// Uses chb_pkg; produces one result word per accepted body word.
`timescale 1ns / 1ps

module chb_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               body_byte,
	input  logic                     body_start,
	output chb_pkg::result_t         result
);

	chb_pkg::phase_t                     phase_q, cur_phase, nxt_phase;
	logic [chb_pkg::SIZE_BITS-1:0]       rem_q, cur_rem, nxt_rem;
	logic [chb_pkg::DIGIT_BITS-1:0]      digits_q, cur_digits, nxt_digits;
	logic [chb_pkg::TOTAL_BITS-1:0]      cnt_q, cur_cnt, nxt_cnt;
	logic                                pass;
	chb_pkg::hex_t                       hex;

	// Restart from reset values when the word marks a new body
	always_comb begin
		cur_phase  = body_start ? chb_pkg::PH_SIZE : phase_q;
		cur_rem    = body_start ? '0 : rem_q;
		cur_digits = body_start ? '0 : digits_q;
		cur_cnt    = body_start ? '0 : cnt_q;
	end

	// Next-state logic
	always_comb begin
		hex        = chb_pkg::hex_value(body_byte);
		nxt_phase  = cur_phase;
		nxt_rem    = cur_rem;
		nxt_digits = cur_digits;
		nxt_cnt    = cur_cnt;
		pass       = 1'b0;
		unique case (cur_phase)
			chb_pkg::PH_SIZE: begin
				if (hex.ok) begin
					if (cur_digits >= chb_pkg::DIGITS_MAX ||
					    (|cur_rem[chb_pkg::SIZE_BITS-1 -: chb_pkg::HEX_BITS])) begin
						nxt_phase = chb_pkg::PH_ERROR;
					end else begin
						nxt_rem    = {cur_rem[chb_pkg::SIZE_BITS-chb_pkg::HEX_BITS-1:0],
						              hex.val};
						nxt_digits = cur_digits + 1'b1;
					end
				end else if (body_byte == chb_pkg::BYTE_CR && cur_digits != '0) begin
					nxt_phase = chb_pkg::PH_SIZE_LF;
				end else begin
					nxt_phase = chb_pkg::PH_ERROR;
				end
			end
			chb_pkg::PH_SIZE_LF: begin
				if (body_byte != chb_pkg::BYTE_LF) begin
					nxt_phase = chb_pkg::PH_ERROR;
				end else if (cur_rem == '0) begin
					nxt_phase = chb_pkg::PH_LAST_CR;
				end else begin
					nxt_phase = chb_pkg::PH_DATA;
				end
				nxt_digits = '0;
			end
			chb_pkg::PH_DATA: begin
				pass    = 1'b1;
				nxt_rem = cur_rem - 1'b1;
				if (cur_cnt != '1) begin
					nxt_cnt = cur_cnt + 1'b1;
				end
				if (cur_rem == chb_pkg::SIZE_BITS'(1)) begin
					nxt_phase = chb_pkg::PH_DATA_CR;
				end
			end
			chb_pkg::PH_DATA_CR: begin
				nxt_phase = (body_byte == chb_pkg::BYTE_CR) ? chb_pkg::PH_DATA_LF
				                                           : chb_pkg::PH_ERROR;
			end
			chb_pkg::PH_DATA_LF: begin
				nxt_phase = (body_byte == chb_pkg::BYTE_LF) ? chb_pkg::PH_SIZE
				                                           : chb_pkg::PH_ERROR;
			end
			chb_pkg::PH_LAST_CR: begin
				nxt_phase = (body_byte == chb_pkg::BYTE_CR) ? chb_pkg::PH_LAST_LF
				                                           : chb_pkg::PH_ERROR;
			end
			chb_pkg::PH_LAST_LF: begin
				nxt_phase = (body_byte == chb_pkg::BYTE_LF) ? chb_pkg::PH_DONE
				                                           : chb_pkg::PH_ERROR;
			end
			chb_pkg::PH_DONE: begin
				nxt_phase = chb_pkg::PH_DONE;
			end
			default: begin
				nxt_phase = chb_pkg::PH_ERROR;
			end
		endcase
	end

	// Build the result word for this byte
	always_comb begin
		result.payload_byte  = pass ? body_byte : 8'h00;
		result.payload_valid = pass;
		result.decoded_total = nxt_cnt;
		if (nxt_phase == chb_pkg::PH_DONE) begin
			result.decode_status = chb_pkg::ST_DONE;
		end else if (nxt_phase == chb_pkg::PH_ERROR) begin
			result.decode_status = chb_pkg::ST_ERROR;
		end else begin
			result.decode_status = chb_pkg::ST_BUSY;
		end
	end

	// Advance state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= chb_pkg::PH_SIZE;
			rem_q    <= '0;
			digits_q <= '0;
			cnt_q    <= '0;
		end else if (step) begin
			phase_q  <= nxt_phase;
			rem_q    <= nxt_rem;
			digits_q <= nxt_digits;
			cnt_q    <= nxt_cnt;
		end
	end

`ifndef ASSERT_OFF
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == chb_pkg::PH_DATA |-> rem_q != '0)
		else $error("data phase with no bytes due");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !body_start && phase_q == chb_pkg::PH_ERROR) |=>
		phase_q == chb_pkg::PH_ERROR)
		else $error("error state left without restart");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !body_start && phase_q == chb_pkg::PH_DONE) |=>
		phase_q == chb_pkg::PH_DONE)
		else $error("done state left without restart");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !body_start) |=> cnt_q >= $past(cnt_q))
		else $error("payload count went down");

	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		digits_q <= chb_pkg::DIGITS_MAX)
		else $error("size digit count out of range");
`endif

endmodule

// ===== rtl/chb_out_reg.sv =====
// Output register for the chunked body decoder result channel.
// Uses chb_pkg; frees the input side whenever the held word is taken.
`timescale 1ns / 1ps

module chb_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  chb_pkg::result_t din,
	output logic             free,
	output logic             result_valid,
	input  logic             result_ready,
	output chb_pkg::result_t dout
);

	logic             valid_q;
	chb_pkg::result_t data_q;

	// Accept a new word when empty or when the held word leaves now
	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign dout         = data_q;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_ready) |-> !load)
		else $error("held result overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && result_ready && !load) |=> !valid_q)
		else $error("taken result still presented");
`endif

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
// Instantiates chb_parser and chb_out_reg; uses chb_pkg.
//
//  channel  handshake                   words
//  body     body_valid / body_ready     body_byte, body_start
//  result   result_valid / result_ready payload_byte, payload_valid,
//                                       decode_status, decoded_total
//
// One body word enters per cycle while body_ready is high; each gives one
// result word in the cycle after. The parser updates its state in the cycle
// the word is accepted; the result lands in a single output register.
// body_ready is low only while a result waits and result_ready is low.
// arst_n clears the parser to the start of a size line and empties the output.
`timescale 1ns / 1ps

module http_chunked_body_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           body_valid,
	output logic                           body_ready,
	input  logic [7:0]                     body_byte,
	input  logic                           body_start,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [7:0]                     payload_byte,
	output logic                           payload_valid,
	output logic [1:0]                     decode_status,
	output logic [chb_pkg::TOTAL_BITS-1:0] decoded_total
);

	logic             step;
	logic             free;
	chb_pkg::result_t res_c;
	chb_pkg::result_t res_q;

	assign body_ready = free;
	assign step       = body_valid && free;

	chb_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.body_byte  (body_byte),
		.body_start (body_start),
		.result     (res_c)
	);

	chb_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.din          (res_c),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.dout         (res_q)
	);

	// Unpack the result word onto the ports
	assign payload_byte  = res_q.payload_byte;
	assign payload_valid = res_q.payload_valid;
	assign decode_status = res_q.decode_status;
	assign decoded_total = res_q.decoded_total;

endmodule
